// ----- rtl/ccoa_pkg.sv -----
// shared constants, types and helpers for the client clock offset averager
package ccoa_pkg;

	localparam int HISTORY_LIMIT = 7;
	localparam int CLIENTS       = 16;
	localparam int WINDOW_LEN    = HISTORY_LIMIT + 1;

	localparam int ID_W   = 4;
	localparam int TIME_W = 48;
	localparam int OFS_W  = 50;
	localparam int HELD_W = 4;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int CID_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int SUM_W  = OFS_W + SLOT_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int SMP_AW = CID_W + SLOT_W;
	localparam int SMP_DEPTH = CLIENTS << SLOT_W;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic [SLOT_W-1:0]       oldest;
		logic signed [SUM_W-1:0] sum;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// fold an out-of-range client id back into the table
	function automatic logic [CID_W-1:0] reduce_cid(input logic [ID_W-1:0] id);
		int r;
		r = int'(id);
		for (int k = 0; k < (1 << ID_W); k++) begin
			if (r >= CLIENTS) begin
				r = r - CLIENTS;
			end
		end
		return CID_W'(r);
	endfunction

	// ring position wrap, input stays below twice the window
	function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] v);
		logic [SLOT_W:0] w;
		w = (v >= (SLOT_W+1)'(WINDOW_LEN)) ? v - (SLOT_W+1)'(WINDOW_LEN) : v;
		return w[SLOT_W-1:0];
	endfunction

endpackage

// ----- rtl/client_clock_offset_averager_top.sv -----
// client clock offset averager: per-client windowed mean of pong offsets
//
// a command word is taken on a rising edge where start is high and busy is
// low; it carries the client id and the three timestamps of one pong reply.
// the block computes the offset, adds it to the client's ring of up to
// HISTORY_LIMIT+1 samples and divides the running sum by the sample count.
// one result word per command comes out on result_client, new_offset,
// average_offset and samples_held, marked by done for exactly one cycle.
// the receiver cannot stall; the result is simply presented for that cycle.
// from accept to done a command passes ST_OFS, ST_META, ST_WB, ST_DIV and
// ST_OUT, with ST_OLD added once the window is full (extra read of the oldest
// sample). ST_DIV is a bit-serial signed divider, one quotient bit per cycle
// over the width of the window sum. busy stays high from accept until the
// cycle that done shows, so one command is in flight at a time.
// per-client window state sits in two rams with registered reads; only the
// client-seen bits are flip-flops. reset clears the seen bits and control,
// so every client starts over with its next sample; no clearing pass needed.
module client_clock_offset_averager_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ccoa_pkg::ID_W-1:0]    client_id,
	input  logic [ccoa_pkg::TIME_W-1:0]  ping_sent_time,
	input  logic [ccoa_pkg::TIME_W-1:0]  ping_received_time,
	input  logic [ccoa_pkg::TIME_W-1:0]  pong_arrival_time,
	output logic                         done,
	output logic [ccoa_pkg::ID_W-1:0]    result_client,
	output logic signed [ccoa_pkg::OFS_W-1:0] new_offset,
	output logic signed [ccoa_pkg::OFS_W-1:0] average_offset,
	output logic [ccoa_pkg::HELD_W-1:0]  samples_held
);

	import ccoa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFS,
		ST_META,
		ST_OLD,
		ST_WB,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [CLIENTS-1:0]      seen_q;
	logic [CID_W-1:0]        cid_q;
	logic signed [OFS_W-1:0] diff_q;
	logic [TIME_W-2:0]       half_q;
	logic signed [OFS_W-1:0] offset_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       old_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic                    done_q;
	logic [ID_W-1:0]         result_client_q;
	logic signed [OFS_W-1:0] new_offset_q;
	logic signed [OFS_W-1:0] average_offset_q;
	logic [HELD_W-1:0]       samples_held_q;

	logic                    accept;
	logic [TIME_W-1:0]       trip;
	meta_t                   meta_rd;
	meta_t                   meta_wr;
	logic                    meta_we;
	logic [SMP_AW-1:0]       smp_raddr;
	logic [SMP_AW-1:0]       smp_waddr;
	logic                    smp_we;
	logic [OFS_W-1:0]        smp_rdata;
	logic [META_W-1:0]       meta_rdata;
	logic                    seen;
	logic                    full;
	logic [SLOT_W-1:0]       fill_slot;
	logic signed [SUM_W-1:0] sum_add;
	logic [SUM_W-1:0]        sum_mag;
	logic [CNT_W:0]          shifted;
	logic                    ge;
	logic [CNT_W:0]          rem_sub;
	logic [SUM_W-1:0]        quo_signed;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign trip   = pong_arrival_time - ping_sent_time;

	assign meta_rd   = meta_t'(meta_rdata);
	assign seen      = seen_q[cid_q];
	assign full      = (meta_rd.cnt >= CNT_W'(WINDOW_LEN));
	assign fill_slot = slot_wrap({1'b0, meta_rd.oldest} + (SLOT_W+1)'(meta_rd.cnt));
	assign sum_add   = meta_rd.sum + SUM_W'(offset_q);
	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign ge      = (shifted >= {1'b0, cnt_q});
	assign rem_sub = shifted - {1'b0, cnt_q};
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	assign meta_we        = (state_q == ST_WB);
	assign meta_wr.cnt    = cnt_q;
	assign meta_wr.oldest = old_q;
	assign meta_wr.sum    = sum_q;

	assign smp_raddr = {cid_q, meta_rd.oldest};

	always_comb begin
		smp_we    = 1'b0;
		smp_waddr = {cid_q, fill_slot};
		case (state_q)
			ST_META: begin
				if (!seen) begin
					smp_we    = 1'b1;
					smp_waddr = {cid_q, SLOT_W'(0)};
				end else if (!full) begin
					smp_we    = 1'b1;
					smp_waddr = {cid_q, fill_slot};
				end
			end
			ST_OLD: begin
				smp_we    = 1'b1;
				smp_waddr = {cid_q, slot_q};
			end
			default: begin
				smp_we = 1'b0;
			end
		endcase
	end

	ccoa_ram #(
		.WIDTH (META_W),
		.DEPTH (CLIENTS),
		.ADDR_W(CID_W)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(cid_q),
		.wdata(META_W'(meta_wr)),
		.raddr(cid_q),
		.rdata(meta_rdata)
	);

	ccoa_ram #(
		.WIDTH (OFS_W),
		.DEPTH (SMP_DEPTH),
		.ADDR_W(SMP_AW)
	) u_smp_ram (
		.clk  (clk),
		.we   (smp_we),
		.waddr(smp_waddr),
		.wdata(OFS_W'(offset_q)),
		.raddr(smp_raddr),
		.rdata(smp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			seen_q           <= '0;
			done_q           <= 1'b0;
			cid_q            <= '0;
			diff_q           <= '0;
			half_q           <= '0;
			offset_q         <= '0;
			cnt_q            <= '0;
			old_q            <= '0;
			slot_q           <= '0;
			sum_q            <= '0;
			neg_q            <= 1'b0;
			quo_q            <= '0;
			rem_q            <= '0;
			step_q           <= '0;
			result_client_q  <= '0;
			new_offset_q     <= '0;
			average_offset_q <= '0;
			samples_held_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cid_q   <= reduce_cid(client_id);
						diff_q  <= $signed(OFS_W'(ping_received_time))
							- $signed(OFS_W'(ping_sent_time));
						half_q  <= trip[TIME_W-1:1];
						state_q <= ST_OFS;
					end
				end
				ST_OFS: begin
					offset_q <= diff_q - $signed(OFS_W'(half_q));
					state_q  <= ST_META;
				end
				ST_META: begin
					seen_q[cid_q] <= 1'b1;
					if (!seen) begin
						cnt_q   <= CNT_W'(1);
						old_q   <= '0;
						sum_q   <= SUM_W'(offset_q);
						state_q <= ST_WB;
					end else if (full) begin
						cnt_q   <= CNT_W'(WINDOW_LEN);
						slot_q  <= meta_rd.oldest;
						old_q   <= slot_wrap({1'b0, meta_rd.oldest} + (SLOT_W+1)'(1));
						sum_q   <= sum_add;
						state_q <= ST_OLD;
					end else begin
						cnt_q   <= meta_rd.cnt + CNT_W'(1);
						old_q   <= meta_rd.oldest;
						sum_q   <= sum_add;
						state_q <= ST_WB;
					end
				end
				ST_OLD: begin
					// oldest sample leaves the window
					sum_q   <= sum_q - SUM_W'($signed(smp_rdata));
					state_q <= ST_WB;
				end
				ST_WB: begin
					neg_q   <= sum_q[SUM_W-1];
					quo_q   <= sum_mag;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? rem_sub[CNT_W-1:0] : shifted[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], ge};
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_OUT: begin
					result_client_q  <= ID_W'(cid_q);
					new_offset_q     <= offset_q;
					average_offset_q <= $signed(quo_signed[OFS_W-1:0]);
					samples_held_q   <= HELD_W'(cnt_q);
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign result_client  = result_client_q;
	assign new_offset     = new_offset_q;
	assign average_offset = average_offset_q;
	assign samples_held   = samples_held_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("accepted word did not raise busy");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (samples_held != '0) && (samples_held <= HELD_W'(WINDOW_LEN)))
		else $error("sample count out of window range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cnt_q))
		else $error("divider remainder not below divisor");

	a_seen_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		meta_we |-> seen_q[cid_q])
		else $error("window written back for a client not marked seen");

endmodule

// ----- rtl/ccoa_ram.sv -----
// generic single-port-write, registered-read ram
module ccoa_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- tb/sv/client_clock_offset_averager_top_test.sv -----
// testbench for the client clock offset averager: directed and random pong words checked against a predictor
`timescale 1ns / 1ps

module client_clock_offset_averager_top_test;

	import ccoa_pkg::*;

	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0]          cid;
		logic signed [OFS_W-1:0]  ofs;
		logic signed [OFS_W-1:0]  avg;
		logic [HELD_W-1:0]        held;
	} offset_word_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [ID_W-1:0]            client_id;
	logic [TIME_W-1:0]          ping_sent_time;
	logic [TIME_W-1:0]          ping_received_time;
	logic [TIME_W-1:0]          pong_arrival_time;
	logic                       done;
	logic [ID_W-1:0]            result_client;
	logic signed [OFS_W-1:0]    new_offset;
	logic signed [OFS_W-1:0]    average_offset;
	logic [HELD_W-1:0]          samples_held;

	offset_word_t pending_offsets[$];

	bit     client_seen[CLIENTS];
	longint offset_ring[CLIENTS][WINDOW_LEN];
	int     ring_count[CLIENTS];
	int     ring_oldest[CLIENTS];
	longint ring_sum[CLIENTS];

	int     sender_idle_pct;
	int     failures;
	int     words_sent;
	int     words_checked;
	int     window_slides;
	longint cycles;

	client_clock_offset_averager_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.client_id          (client_id),
		.ping_sent_time     (ping_sent_time),
		.ping_received_time (ping_received_time),
		.pong_arrival_time  (pong_arrival_time),
		.done               (done),
		.result_client      (result_client),
		.new_offset         (new_offset),
		.average_offset     (average_offset),
		.samples_held       (samples_held)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("client_clock_offset_averager_top: mismatch");
			$finish;
		end
	end

	function automatic offset_word_t predict_pong(input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] sent, input logic [TIME_W-1:0] recv,
			input logic [TIME_W-1:0] arrive);
		int c;
		int slot;
		logic [TIME_W-1:0] trip;
		longint ofs;
		longint avg;
		offset_word_t w;
		c = int'(id) % CLIENTS;
		trip = arrive - sent;
		ofs = longint'(recv) - longint'(sent) - longint'(trip >> 1);
		if (!client_seen[c]) begin
			client_seen[c] = 1'b1;
			offset_ring[c][0] = ofs;
			ring_oldest[c] = 0;
			ring_count[c] = 1;
			ring_sum[c] = ofs;
			avg = ofs;
		end else begin
			if (ring_count[c] >= WINDOW_LEN) begin
				slot = ring_oldest[c];
				ring_sum[c] -= offset_ring[c][slot];
				offset_ring[c][slot] = ofs;
				ring_oldest[c] = (slot + 1) % WINDOW_LEN;
				window_slides++;
			end else begin
				offset_ring[c][(ring_oldest[c] + ring_count[c]) % WINDOW_LEN] = ofs;
				ring_count[c]++;
			end
			ring_sum[c] += ofs;
			avg = ring_sum[c] / longint'(ring_count[c]);
		end
		w.cid = ID_W'(c);
		w.ofs = ofs[OFS_W-1:0];
		w.avg = avg[OFS_W-1:0];
		w.held = HELD_W'(ring_count[c]);
		return w;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(2))
			0: return '0;
			1: return TIME_MAX;
			default: return rand_time();
		endcase
	endfunction

	always @(posedge clk) begin
		offset_word_t e;
		if (arst_n && done) begin
			if (pending_offsets.size() == 0) begin
				$error("unexpected result word: client %0d offset %0d", result_client,
					new_offset);
				failures++;
			end else begin
				e = pending_offsets.pop_front();
				words_checked++;
				if (result_client !== e.cid) begin
					$error("result_client: expected %0d, got %0d", e.cid, result_client);
					failures++;
				end
				if (new_offset !== e.ofs) begin
					$error("new_offset: expected %0d, got %0d", e.ofs, new_offset);
					failures++;
				end
				if (average_offset !== e.avg) begin
					$error("average_offset: expected %0d, got %0d", e.avg, average_offset);
					failures++;
				end
				if (samples_held !== e.held) begin
					$error("samples_held: expected %0d, got %0d", e.held, samples_held);
					failures++;
				end
			end
		end
	end

	task automatic send_pong(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] sent,
			input logic [TIME_W-1:0] recv, input logic [TIME_W-1:0] arrive);
		if ($urandom_range(99) < sender_idle_pct)
			repeat ($urandom_range(1, 80)) @(negedge clk);
		start = 1'b1;
		client_id = id;
		ping_sent_time = sent;
		ping_received_time = recv;
		pong_arrival_time = arrive;
		do @(posedge clk); while (busy);
		pending_offsets.push_back(predict_pong(id, sent, recv, arrive));
		words_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_offsets.size() != 0) @(negedge clk);
	endtask

	task automatic test_field_extremes();
		send_pong(0, '0, '0, '0);
		send_pong(15, TIME_MAX, TIME_MAX, TIME_MAX);
		send_pong(1, '0, TIME_MAX, '0);
		send_pong(2, TIME_MAX, '0, TIME_MAX - 1);
		send_pong(15, TIME_MAX, '0, TIME_MAX - 1);
		send_pong(1, '0, TIME_MAX, TIME_MAX);
	endtask

	task automatic test_pong_before_ping();
		send_pong(4, 48'd5000, 48'd4000, 48'd1000);
		send_pong(4, 48'h8000_0000_0000, 48'h0000_0000_1000, 48'h0);
	endtask

	task automatic test_negative_truncation();
		send_pong(5, 48'd100, 48'd99, 48'd100);
		send_pong(5, 48'd100, 48'd98, 48'd100);
		send_pong(6, 48'd100, 48'd101, 48'd100);
		send_pong(6, 48'd100, 48'd102, 48'd100);
	endtask

	task automatic test_window_wrap();
		logic [TIME_W-1:0] t;
		for (int i = 0; i < 11; i++) begin
			t = TIME_W'(1000 * (i + 1));
			send_pong(3, t, t + TIME_W'(i * 37) - 48'd150, t + TIME_W'(2 * i + 1));
		end
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input bit pause_midway);
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] sent;
		logic [TIME_W-1:0] recv;
		logic [TIME_W-1:0] arrive;
		int rtt;
		int drift;
		int k;
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			if (pause_midway && n == count / 2)
				drain_results();
			id = ID_W'($urandom);
			k = $urandom_range(99);
			if (k < 70) begin
				sent = rand_time();
				rtt = $urandom_range(0, 200000);
				drift = int'($urandom_range(0, 2000000)) - 1000000;
				recv = sent + TIME_W'(rtt / 2) + TIME_W'(drift);
				arrive = sent + TIME_W'(rtt);
			end else if (k < 85) begin
				sent = pick_time();
				recv = pick_time();
				arrive = pick_time();
			end else begin
				sent = rand_time();
				recv = rand_time();
				arrive = rand_time();
			end
			send_pong(id, sent, recv, arrive);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		client_id = '0;
		ping_sent_time = '0;
		ping_received_time = '0;
		pong_arrival_time = '0;
		sender_idle_pct = 0;
		failures = 0;
		words_sent = 0;
		words_checked = 0;
		window_slides = 0;
		cycles = 0;
		for (int c = 0; c < CLIENTS; c++) begin
			client_seen[c] = 1'b0;
			ring_count[c] = 0;
			ring_oldest[c] = 0;
			ring_sum[c] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_field_extremes();
		test_pong_before_ping();
		test_negative_truncation();
		test_window_wrap();
		test_random_traffic(225, 0, 1'b0);
		test_random_traffic(225, 81, 1'b1);
		test_random_traffic(225, 0, 1'b0);
		test_random_traffic(225, 26, 1'b0);

		drain_results();
		repeat (80) @(posedge clk);
		$display("sent %0d pong words, checked %0d results, %0d window slides",
			words_sent, words_checked, window_slides);
		$display("covered timestamp extremes, wrapped round trips and idle gaps");
		if (failures == 0 && pending_offsets.size() == 0)
			$display("client_clock_offset_averager_top: match");
		else
			$display("client_clock_offset_averager_top: mismatch");
		$finish;
	end

endmodule
